// ===== sv/line_sensor_spi_responder_unit_assert.svh =====
// assertion macros for the line sensor responder checker
// no dependencies; included by the checker file
`ifndef LINE_SENSOR_SPI_RESPONDER_UNIT_ASSERT_SVH
`define LINE_SENSOR_SPI_RESPONDER_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is held
`define LSSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define LSSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define LSSR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lssr_pkg.sv =====
// types, constants and decode helpers for the line sensor responder
// no dependencies; used by every other file of the block but the assertion header
`timescale 1ns / 1ps

package lssr_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int BYTE_W      = 8;
    localparam int LANES       = 3;
    localparam int LANE_IW     = $clog2(LANES);
    localparam int ADC_MAX_DEF = 1023;

    // command codes
    localparam logic [BYTE_W-1:0] OP_NULL      = 8'd0;
    localparam logic [BYTE_W-1:0] OP_RAW_FIRST = 8'd1;
    localparam logic [BYTE_W-1:0] OP_RAW_LAST  = 8'd6;
    localparam logic [BYTE_W-1:0] OP_CAL_FIRST = 8'd7;
    localparam logic [BYTE_W-1:0] OP_CAL_LAST  = 8'd12;
    localparam logic [BYTE_W-1:0] OP_TRACK_A   = 8'd13;
    localparam logic [BYTE_W-1:0] OP_TRACK_O   = 8'd14;
    localparam logic [BYTE_W-1:0] OP_MASK      = 8'd15;
    localparam logic [BYTE_W-1:0] OP_DIR       = 8'd16;

    // reply characters
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_L     = 8'h4C;
    localparam logic [BYTE_W-1:0] CH_I     = 8'h49;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
    localparam logic [BYTE_W-1:0] CH_U     = 8'h55;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;

    // direction masks
    localparam logic [LANES-1:0] MASK_RIGHT = 3'b001;
    localparam logic [LANES-1:0] MASK_INNER = 3'b010;
    localparam logic [LANES-1:0] MASK_LEFT  = 3'b100;
    localparam logic [LANES-1:0] MASK_CROSS = 3'b111;
    localparam logic [LANES-1:0] MASK_TEE   = 3'b101;

    typedef struct packed {
        logic track;    // fold reading into min and max
        logic set_thr;  // store the new midpoint
    } t_lane_ctl;

    typedef struct packed {
        logic [BYTE_W-1:0] raw_lo;
        logic [BYTE_W-1:0] raw_hi;
        logic [BYTE_W-1:0] thr_lo;
        logic [BYTE_W-1:0] thr_hi;
        logic              above;
    } t_lane_res;

    function automatic t_lane_ctl lane_ctl(input logic [BYTE_W-1:0] op,
                                           input logic accept,
                                           input logic [LANE_IW-1:0] lane);
        logic [BYTE_W-1:0] op_off;
        logic              cal_hit;
        logic              all_hit;
        t_lane_ctl         ctl;
        op_off  = op - OP_CAL_FIRST;
        cal_hit = (op >= OP_CAL_FIRST) && (op <= OP_CAL_LAST) &&
                  (op_off[LANE_IW:1] == lane);
        all_hit = (op == OP_TRACK_A) || (op == OP_TRACK_O);
        ctl.track   = accept && (cal_hit || all_hit);
        ctl.set_thr = accept && cal_hit;
        return ctl;
    endfunction

    function automatic logic [BYTE_W-1:0] dir_letter(input logic [LANES-1:0] mask);
        logic [BYTE_W-1:0] ch;
        case (mask)
            MASK_RIGHT: ch = CH_R;
            MASK_LEFT:  ch = CH_L;
            MASK_INNER: ch = CH_I;
            MASK_CROSS: ch = CH_PLUS;
            MASK_TEE:   ch = CH_T;
            default:    ch = CH_U;
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/lssr_in_if.sv =====
// command channel: command byte plus three channel readings
// depends on lssr_pkg for field widths
`timescale 1ns / 1ps

interface lssr_in_if;
    logic                         valid;
    logic                         ready;
    logic [lssr_pkg::BYTE_W-1:0]  operation;
    logic [lssr_pkg::SAMPLE_W-1:0] sample_ch0;
    logic [lssr_pkg::SAMPLE_W-1:0] sample_ch1;
    logic [lssr_pkg::SAMPLE_W-1:0] sample_ch2;

    modport source (output valid, operation, sample_ch0, sample_ch1, sample_ch2,
                    input ready);
    modport sink (input valid, operation, sample_ch0, sample_ch1, sample_ch2,
                  output ready);
endinterface

// ===== sv/lssr_out_if.sv =====
// reply channel: one reply byte per command
// depends on lssr_pkg for the byte width
`timescale 1ns / 1ps

interface lssr_out_if;
    logic                        valid;
    logic                        ready;
    logic [lssr_pkg::BYTE_W-1:0] reply_byte;

    modport source (output valid, reply_byte, input ready);
    modport sink (input valid, reply_byte, output ready);
endinterface

// ===== sv/lssr_lane.sv =====
// one channel lane: running min/max, stored threshold and compare
// depends on lssr_pkg
`timescale 1ns / 1ps

module lssr_lane #(
    parameter int ADC_MAX = lssr_pkg::ADC_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lssr_pkg::SAMPLE_W-1:0] i_sample,
    input  lssr_pkg::t_lane_ctl           i_ctl,
    output lssr_pkg::t_lane_res           o_res
);
    localparam int AW = $clog2(ADC_MAX + 1);
    localparam int RW = (AW > lssr_pkg::SAMPLE_W) ? AW : lssr_pkg::SAMPLE_W;

    logic [RW-1:0] r_min;
    logic [RW-1:0] r_max;
    logic [RW-1:0] r_thr;
    logic [RW-1:0] n_min;
    logic [RW-1:0] n_max;
    logic [RW-1:0] n_thr;
    logic [RW-1:0] sample_x;
    logic [RW:0]   mid_sum;
    logic [RW+7:0] thr_ext;

    always_comb begin
        sample_x = RW'(i_sample);
        n_min    = (sample_x < r_min) ? sample_x : r_min;
        n_max    = (sample_x > r_max) ? sample_x : r_max;
        mid_sum  = {1'b0, n_min} + {1'b0, n_max};
        n_thr    = mid_sum[RW:1];
        thr_ext  = (RW + 8)'(n_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= RW'(ADC_MAX);
            r_max <= '0;
            r_thr <= '0;
        end else begin
            if (i_ctl.track) begin
                r_min <= n_min;
                r_max <= n_max;
            end
            if (i_ctl.set_thr) begin
                r_thr <= n_thr;
            end
        end
    end

    always_comb begin
        o_res.raw_lo = i_sample[7:0];
        o_res.raw_hi = 8'(i_sample >> 8);
        o_res.thr_lo = n_thr[7:0];
        o_res.thr_hi = thr_ext[15:8];
        o_res.above  = sample_x > r_thr;
    end
endmodule

// ===== sv/lssr_merge.sv =====
// reply merge: picks the reply from the lane results and holds it for output
// depends on lssr_pkg
`timescale 1ns / 1ps

module lssr_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [lssr_pkg::BYTE_W-1:0]       i_op,
    input  lssr_pkg::t_lane_res               i_res [lssr_pkg::LANES],
    input  logic                              i_out_ready,
    output logic                              o_in_ready,
    output logic                              o_valid,
    output logic [lssr_pkg::BYTE_W-1:0]       o_reply
);
    logic                              r_valid;
    logic [lssr_pkg::BYTE_W-1:0]       r_last;
    logic [lssr_pkg::BYTE_W-1:0]       n_last;
    logic [lssr_pkg::BYTE_W-1:0]       raw_off;
    logic [lssr_pkg::BYTE_W-1:0]       cal_off;
    logic [lssr_pkg::LANE_IW-1:0]      raw_ch;
    logic [lssr_pkg::LANE_IW-1:0]      cal_ch;
    logic [lssr_pkg::LANES-1:0]        mask;
    lssr_pkg::t_lane_res               raw_res;
    lssr_pkg::t_lane_res               cal_res;

    always_comb begin
        raw_off = i_op - lssr_pkg::OP_RAW_FIRST;
        cal_off = i_op - lssr_pkg::OP_CAL_FIRST;
        raw_ch  = raw_off[lssr_pkg::LANE_IW:1];
        cal_ch  = cal_off[lssr_pkg::LANE_IW:1];
        raw_res = i_res[0];
        cal_res = i_res[0];
        for (int c = 0; c < lssr_pkg::LANES; c++) begin
            mask[c] = i_res[c].above;
            if (raw_ch == lssr_pkg::LANE_IW'(c)) begin
                raw_res = i_res[c];
            end
            if (cal_ch == lssr_pkg::LANE_IW'(c)) begin
                cal_res = i_res[c];
            end
        end

        // odd raw and threshold commands take the low byte, even ones the high byte
        n_last = r_last;
        if (i_op == lssr_pkg::OP_NULL) begin
            n_last = '0;
        end else if (i_op <= lssr_pkg::OP_RAW_LAST) begin
            n_last = i_op[0] ? raw_res.raw_lo : raw_res.raw_hi;
        end else if (i_op <= lssr_pkg::OP_CAL_LAST) begin
            n_last = i_op[0] ? cal_res.thr_lo : cal_res.thr_hi;
        end else if (i_op == lssr_pkg::OP_TRACK_A) begin
            n_last = lssr_pkg::CH_A;
        end else if (i_op == lssr_pkg::OP_TRACK_O) begin
            n_last = lssr_pkg::CH_O;
        end else if (i_op == lssr_pkg::OP_MASK) begin
            n_last = lssr_pkg::BYTE_W'(mask);
        end else if (i_op == lssr_pkg::OP_DIR) begin
            n_last = lssr_pkg::dir_letter(mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= lssr_pkg::CH_ZERO;
        end else if (i_accept) begin
            r_valid <= 1'b1;
            r_last  <= n_last;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_in_ready = !r_valid || i_out_ready;
    assign o_valid    = r_valid;
    assign o_reply    = r_last;
endmodule

// ===== sv/line_sensor_spi_responder_unit.sv =====
// Three-channel line sensor responder.
// Input channel i_in carries a command byte and the current readings of three
// channels; output channel o_out carries one reply byte for every command.
// Both channels move an item when valid and ready are high at a clock edge.
// Each channel has its own lane (min, max, threshold, compare); the merge stage
// selects the reply and holds it in the output register.
// The reply is registered and appears in the cycle after its command is taken.
// Throughput: one command per cycle while replies are taken; the output
// register is the only stage, and a new command is taken in the same cycle
// its predecessor's reply leaves. When the receiver stalls, the reply holds
// and i_in.ready drops until it is taken, so no lane state moves.
// Reset (synchronous, i_rst_n low) sets every minimum to ADC_MAX, every maximum
// and threshold to zero, the remembered reply to ASCII zero, and empties the
// output register.
// depends on lssr_pkg, lssr_in_if, lssr_out_if, lssr_lane, lssr_merge
`timescale 1ns / 1ps

module line_sensor_spi_responder_unit #(
    parameter int ADC_MAX = lssr_pkg::ADC_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lssr_in_if.sink     i_in,
    lssr_out_if.source  o_out
);
    logic                                  accept;
    logic                                  in_ready;
    logic [lssr_pkg::SAMPLE_W-1:0]         samples [lssr_pkg::LANES];
    lssr_pkg::t_lane_ctl                   ctl     [lssr_pkg::LANES];
    lssr_pkg::t_lane_res                   res     [lssr_pkg::LANES];

    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;
    assign samples[0] = i_in.sample_ch0;
    assign samples[1] = i_in.sample_ch1;
    assign samples[2] = i_in.sample_ch2;

    for (genvar g = 0; g < lssr_pkg::LANES; g++) begin : g_lane
        assign ctl[g] = lssr_pkg::lane_ctl(i_in.operation, accept,
                                           lssr_pkg::LANE_IW'(g));

        lssr_lane #(
            .ADC_MAX (ADC_MAX)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_sample (samples[g]),
            .i_ctl    (ctl[g]),
            .o_res    (res[g])
        );
    end

    lssr_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (i_in.operation),
        .i_res       (res),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_valid     (o_out.valid),
        .o_reply     (o_out.reply_byte)
    );
endmodule

// ===== sv/lssr_check.sv =====
// port-level checker for the line sensor responder, bound to the top level
// depends on lssr_pkg and line_sensor_spi_responder_unit_assert.svh
`timescale 1ns / 1ps
`include "line_sensor_spi_responder_unit_assert.svh"

module lssr_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic [lssr_pkg::BYTE_W-1:0] i_op,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [lssr_pkg::BYTE_W-1:0] i_reply
);
    `LSSR_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid, "output not empty after reset")
    `LSSR_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "not ready while output empty")
    `LSSR_ASSERT_NEXT(a_accept_gives_reply, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid, "no reply after taken item")
    `LSSR_ASSERT_NEXT(a_null_reply, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_op == lssr_pkg::OP_NULL), i_reply == '0, "null command reply not zero")
    `LSSR_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_reply), "stalled reply changed")
endmodule

bind line_sensor_spi_responder_unit lssr_check u_lssr_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_op        (i_in.operation),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_reply     (o_out.reply_byte)
);
